### src/tlps_pkg.sv
// ----------------------------------------------------------------------------
// tlps_pkg
// Types and constants for the traffic light pedestrian sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlps_pkg;

  typedef enum logic [1:0] {
    PH_RED        = 2'd0,
    PH_RED_BLINK  = 2'd1,
    PH_GREEN      = 2'd2,
    PH_GREEN_BLINK = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SVC_NONE  = 2'd0,
    SVC_BLINK = 2'd1,
    SVC_WALK  = 2'd2
  } service_t;

  typedef enum logic [1:0] {
    REG_PHASE_SLOTS = 2'd0,
    REG_BLINK_SLOTS = 2'd1,
    REG_WALK_SLOTS  = 2'd2
  } reg_index_t;

  localparam int unsigned LAMP_W  = 6;
  localparam int unsigned SLOT_W  = 4;

  localparam logic [LAMP_W-1:0] LAMP_CG = 6'h01;
  localparam logic [LAMP_W-1:0] LAMP_CY = 6'h02;
  localparam logic [LAMP_W-1:0] LAMP_CR = 6'h04;
  localparam logic [LAMP_W-1:0] LAMP_PG = 6'h08;
  localparam logic [LAMP_W-1:0] LAMP_PY = 6'h10;
  localparam logic [LAMP_W-1:0] LAMP_PR = 6'h20;

  localparam logic [SLOT_W-1:0] SLOTS_RESET = 4'd10;

endpackage

`default_nettype wire

### src/traffic_light_pedestrian_sequencer.sv
// ----------------------------------------------------------------------------
// traffic_light_pedestrian_sequencer
// Car phase loop with a latched pedestrian request and walk service.
//
//   channel  | dir | handshake              | payload
//   s_axis   | in  | s_tvalid / s_tready    | s_tdata: button_press
//   m_axis   | out | m_tvalid / m_tready    | m_tdata: six lamp levels
//   cfg      | in  | cfg_we                 | cfg_index, cfg_data
//
// One slot per cycle unless the receiver stalls: state update and lamp result
// are computed in the accepting cycle and m_tdata shows them in the next cycle.
// s_tready stays high while the result register is empty or being drained.
// Synchronous reset clears state and lamps, and loads all slot counts to 10.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_light_pedestrian_sequencer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [0] button_press, [7:1] zero
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [0] car_green [1] car_yellow [2] car_red
                                     // [3] ped_green [4] ped_yellow [5] ped_red
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data
);

  localparam logic [tlps_pkg::SLOT_W-1:0] ONE_SLOT = 4'd1;

  logic [tlps_pkg::SLOT_W-1:0] phase_slots;
  logic [tlps_pkg::SLOT_W-1:0] blink_slots;
  logic [tlps_pkg::SLOT_W-1:0] walk_slots;

  tlps_pkg::phase_t            phase, phase_next;
  tlps_pkg::service_t          service_step, service_step_next;
  logic [tlps_pkg::SLOT_W-1:0] slot_count, slot_count_next;
  logic                        request_pending, request_pending_next;
  logic [tlps_pkg::LAMP_W-1:0] lamp_levels, lamp_levels_next;
  logic [tlps_pkg::LAMP_W-1:0] lamp_out;

  logic [tlps_pkg::SLOT_W-1:0] phase_len, blink_len, walk_len;
  logic                        accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign phase_len = (phase_slots == '0) ? ONE_SLOT : phase_slots;
  assign blink_len = (blink_slots == '0) ? ONE_SLOT : blink_slots;
  assign walk_len  = (walk_slots  == '0) ? ONE_SLOT : walk_slots;

  always_comb begin
    lamp_levels_next     = lamp_levels;
    phase_next           = phase;
    slot_count_next      = slot_count;
    service_step_next    = service_step;
    request_pending_next = request_pending;

    if (service_step == tlps_pkg::SVC_NONE && request_pending) begin
      request_pending_next = 1'b0;
      slot_count_next      = '0;
      if (phase == tlps_pkg::PH_RED) begin
        lamp_levels_next = lamp_levels_next
                         & ~(tlps_pkg::LAMP_PR | tlps_pkg::LAMP_CG | tlps_pkg::LAMP_CY);
        lamp_levels_next = lamp_levels_next | tlps_pkg::LAMP_CR | tlps_pkg::LAMP_PG;
        service_step_next = tlps_pkg::SVC_WALK;
      end else begin
        lamp_levels_next = lamp_levels_next | tlps_pkg::LAMP_PR;
        lamp_levels_next = lamp_levels_next & ~(tlps_pkg::LAMP_CY | tlps_pkg::LAMP_PY);
        if (phase == tlps_pkg::PH_RED_BLINK) begin
          lamp_levels_next = lamp_levels_next & ~tlps_pkg::LAMP_CR;
        end
        if (phase == tlps_pkg::PH_GREEN_BLINK) begin
          lamp_levels_next = lamp_levels_next & ~tlps_pkg::LAMP_CG;
        end
        service_step_next = tlps_pkg::SVC_BLINK;
      end
    end

    case (service_step_next)
      tlps_pkg::SVC_BLINK: begin
        lamp_levels_next = lamp_levels_next ^ (tlps_pkg::LAMP_CY | tlps_pkg::LAMP_PY);
        lamp_out         = lamp_levels_next;
        slot_count_next  = slot_count_next + ONE_SLOT;
        if (slot_count_next >= blink_len) begin
          lamp_levels_next = lamp_levels_next
                           & ~(tlps_pkg::LAMP_CY | tlps_pkg::LAMP_PY
                               | tlps_pkg::LAMP_PR | tlps_pkg::LAMP_CG);
          lamp_levels_next  = lamp_levels_next | tlps_pkg::LAMP_PG | tlps_pkg::LAMP_CR;
          service_step_next = tlps_pkg::SVC_WALK;
          slot_count_next   = '0;
        end
      end
      tlps_pkg::SVC_WALK: begin
        lamp_out        = lamp_levels_next;
        slot_count_next = slot_count_next + ONE_SLOT;
        if (slot_count_next >= walk_len) begin
          lamp_levels_next = lamp_levels_next & ~tlps_pkg::LAMP_PG;
          if (phase != tlps_pkg::PH_RED) begin
            lamp_levels_next = lamp_levels_next & ~tlps_pkg::LAMP_CR;
          end
          service_step_next = tlps_pkg::SVC_NONE;
          slot_count_next   = '0;
          phase_next        = tlps_pkg::phase_t'(phase + 2'd1);
        end
      end
      default: begin
        lamp_levels_next = lamp_levels_next | tlps_pkg::LAMP_PR;
        case (phase)
          tlps_pkg::PH_RED: begin
            lamp_levels_next = lamp_levels_next & ~(tlps_pkg::LAMP_CG | tlps_pkg::LAMP_CY);
            lamp_levels_next = lamp_levels_next | tlps_pkg::LAMP_CR;
          end
          tlps_pkg::PH_GREEN: begin
            lamp_levels_next = lamp_levels_next & ~(tlps_pkg::LAMP_CR | tlps_pkg::LAMP_CY);
            lamp_levels_next = lamp_levels_next | tlps_pkg::LAMP_CG;
          end
          default: begin
            lamp_levels_next = lamp_levels_next ^ tlps_pkg::LAMP_CY;
          end
        endcase
        lamp_out        = lamp_levels_next;
        slot_count_next = slot_count_next + ONE_SLOT;
        if (slot_count_next >= phase_len) begin
          slot_count_next = '0;
          phase_next      = tlps_pkg::phase_t'(phase + 2'd1);
        end
        if (s_tdata[0]) begin
          request_pending_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_slots <= tlps_pkg::SLOTS_RESET;
      blink_slots <= tlps_pkg::SLOTS_RESET;
      walk_slots  <= tlps_pkg::SLOTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tlps_pkg::REG_PHASE_SLOTS: phase_slots <= cfg_data;
        tlps_pkg::REG_BLINK_SLOTS: blink_slots <= cfg_data;
        tlps_pkg::REG_WALK_SLOTS:  walk_slots  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= tlps_pkg::PH_RED;
      service_step    <= tlps_pkg::SVC_NONE;
      slot_count      <= '0;
      request_pending <= 1'b0;
      lamp_levels     <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      service_step    <= service_step_next;
      slot_count      <= slot_count_next;
      request_pending <= request_pending_next;
      lamp_levels     <= lamp_levels_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, lamp_out};
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for traffic_light_pedestrian_sequencer. Sends button slots over
// the input stream, predicts the six lamp levels of every slot from its own
// copy of the phase, request and service state, and compares each output
// transfer against the oldest prediction. Directed slots cover reset values,
// service in each car phase and presses lost during service. Random slots
// then run under several slot settings, with bursty input, receiver stalls
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         LONG_HOLD   = 80;
  localparam logic [1:0] REG_SPARE   = 2'd3;   // unmapped index, write is ignored

  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'd0;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [3:0] cfg_data  = 4'd0;

  traffic_light_pedestrian_sequencer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // lamp state mirror
  logic [tlps_pkg::SLOT_W-1:0] phase_len  = tlps_pkg::SLOTS_RESET;
  logic [tlps_pkg::SLOT_W-1:0] blink_len  = tlps_pkg::SLOTS_RESET;
  logic [tlps_pkg::SLOT_W-1:0] walk_len   = tlps_pkg::SLOTS_RESET;
  logic [1:0]                  car_phase  = tlps_pkg::PH_RED;
  logic [tlps_pkg::SLOT_W-1:0] slot_cnt   = '0;
  logic [1:0]                  svc_step   = tlps_pkg::SVC_NONE;
  bit                          walk_req   = 1'b0;
  logic [tlps_pkg::LAMP_W-1:0] lamps      = '0;

  logic [tlps_pkg::LAMP_W-1:0] expected_lamps[$];
  string             lamp_name[tlps_pkg::LAMP_W] = '{"car_green", "car_yellow", "car_red",
                                                     "ped_green", "ped_yellow", "ped_red"};
  int                mismatches = 0;
  int                cycle_cnt  = 0;
  int                hold_left  = 0;
  int                ready_mode = RX_ALWAYS;
  int                gap_max    = 0;
  int                burst_left = 0;
  int                press_pct  = 5;
  bit                tvalid_up  = 1'b0;

  function automatic logic [tlps_pkg::SLOT_W-1:0] span(
    input logic [tlps_pkg::SLOT_W-1:0] v);
    return (v == '0) ? 4'd1 : v;
  endfunction

  task automatic advance_slot(input bit press,
                              output logic [tlps_pkg::LAMP_W-1:0] shown);
    if (svc_step == tlps_pkg::SVC_NONE && walk_req) begin
      walk_req = 1'b0;
      slot_cnt = '0;
      if (car_phase == tlps_pkg::PH_RED) begin
        lamps &= ~(tlps_pkg::LAMP_PR | tlps_pkg::LAMP_CG | tlps_pkg::LAMP_CY);
        lamps |= tlps_pkg::LAMP_CR | tlps_pkg::LAMP_PG;
        svc_step = tlps_pkg::SVC_WALK;
      end else begin
        lamps |= tlps_pkg::LAMP_PR;
        lamps &= ~(tlps_pkg::LAMP_CY | tlps_pkg::LAMP_PY);
        if (car_phase == tlps_pkg::PH_RED_BLINK) lamps &= ~tlps_pkg::LAMP_CR;
        if (car_phase == tlps_pkg::PH_GREEN_BLINK) lamps &= ~tlps_pkg::LAMP_CG;
        svc_step = tlps_pkg::SVC_BLINK;
      end
    end

    if (svc_step == tlps_pkg::SVC_BLINK) begin
      lamps ^= tlps_pkg::LAMP_CY | tlps_pkg::LAMP_PY;
      shown = lamps;
      slot_cnt = slot_cnt + 4'd1;
      if (slot_cnt >= span(blink_len)) begin
        lamps &= ~(tlps_pkg::LAMP_CY | tlps_pkg::LAMP_PY
                   | tlps_pkg::LAMP_PR | tlps_pkg::LAMP_CG);
        lamps |= tlps_pkg::LAMP_PG | tlps_pkg::LAMP_CR;
        svc_step = tlps_pkg::SVC_WALK;
        slot_cnt = '0;
      end
    end else if (svc_step == tlps_pkg::SVC_WALK) begin
      shown = lamps;
      slot_cnt = slot_cnt + 4'd1;
      if (slot_cnt >= span(walk_len)) begin
        lamps &= ~tlps_pkg::LAMP_PG;
        if (car_phase != tlps_pkg::PH_RED) lamps &= ~tlps_pkg::LAMP_CR;
        svc_step = tlps_pkg::SVC_NONE;
        slot_cnt = '0;
        car_phase = car_phase + 2'd1;
      end
    end else begin
      lamps |= tlps_pkg::LAMP_PR;
      if (car_phase == tlps_pkg::PH_RED) begin
        lamps &= ~(tlps_pkg::LAMP_CG | tlps_pkg::LAMP_CY);
        lamps |= tlps_pkg::LAMP_CR;
      end else if (car_phase == tlps_pkg::PH_GREEN) begin
        lamps &= ~(tlps_pkg::LAMP_CR | tlps_pkg::LAMP_CY);
        lamps |= tlps_pkg::LAMP_CG;
      end else begin
        lamps ^= tlps_pkg::LAMP_CY;
      end
      shown = lamps;
      slot_cnt = slot_cnt + 4'd1;
      if (slot_cnt >= span(phase_len)) begin
        slot_cnt = '0;
        car_phase = car_phase + 2'd1;
      end
      if (press) walk_req = 1'b1;
    end
  endtask

  task automatic send_slot(input bit press);
    logic [tlps_pkg::LAMP_W-1:0] shown;
    int                          gap;
    bit                          noise;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, press};
    tvalid_up = 1'b1;
    do @(posedge clk); while (!s_tready);
    advance_slot(press, shown);
    expected_lamps.push_back(shown);
    if (burst_left > 0) begin
      burst_left--;
    end else if (gap_max > 0) begin
      gap   = $urandom_range(gap_max, 1);
      noise = 1'($urandom_range(1));
      s_tvalid <= 1'b0;
      s_tdata  <= {7'd0, noise};
      tvalid_up = 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(12);
    end
  endtask

  task automatic drain_results();
    if (tvalid_up) begin
      s_tvalid <= 1'b0;
      tvalid_up = 1'b0;
    end
    while (expected_lamps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [tlps_pkg::SLOT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      tlps_pkg::REG_PHASE_SLOTS: phase_len = val;
      tlps_pkg::REG_BLINK_SLOTS: blink_len = val;
      tlps_pkg::REG_WALK_SLOTS:  walk_len  = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit rand_press();
    return $urandom_range(99) < press_pct;
  endfunction

  // reset values, with one walk in the car red phase
  task automatic test_after_reset();
    gap_max = 0;
    for (int i = 0; i < 6; i++) send_slot(i == 2);
    drain_results();
  endtask

  // walk requested in each car phase; presses during service are lost
  task automatic test_service_per_phase();
    write_reg(tlps_pkg::REG_PHASE_SLOTS, 4'd0);
    write_reg(tlps_pkg::REG_BLINK_SLOTS, 4'd2);
    write_reg(tlps_pkg::REG_WALK_SLOTS, 4'd1);
    for (int t = 0; t < 4; t++) begin
      while (!(car_phase == t[1:0] && svc_step == tlps_pkg::SVC_NONE && !walk_req))
        send_slot(svc_step != tlps_pkg::SVC_NONE || walk_req);
      send_slot(1'b1);
      while (walk_req || svc_step != tlps_pkg::SVC_NONE)
        send_slot(1'b1);
    end
    drain_results();
  endtask

  task automatic test_settings_sweep();
    logic [tlps_pkg::SLOT_W-1:0] ph_set[5] = '{4'd15, 4'd0, 4'd1, 4'd0, 4'd0};
    logic [tlps_pkg::SLOT_W-1:0] bl_set[5] = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd0};
    logic [tlps_pkg::SLOT_W-1:0] wk_set[5] = '{4'd15, 4'd0, 4'd1, 4'd0, 4'd0};
    int                          gaps[5]   = '{0, 3, 8, 2, 5};
    for (int s = 0; s < 5; s++) begin
      if (s >= 3) begin
        ph_set[s] = 4'($urandom_range(15));
        bl_set[s] = 4'($urandom_range(15));
        wk_set[s] = 4'($urandom_range(15));
        write_reg(REG_SPARE, 4'($urandom_range(15)));
      end
      write_reg(tlps_pkg::REG_PHASE_SLOTS, ph_set[s]);
      write_reg(tlps_pkg::REG_BLINK_SLOTS, bl_set[s]);
      write_reg(tlps_pkg::REG_WALK_SLOTS, wk_set[s]);
      ready_mode <= (s == 0) ? RX_ALWAYS : ((s % 2 == 1) ? RX_RANDOM : RX_PATTERN);
      gap_max    = gaps[s];
      press_pct  = $urandom_range(15, 2);
      for (int i = 0; i < 90; i++) send_slot(rand_press());
      drain_results();
    end
  endtask

  // receiver holds off while slots keep coming, then sender waits for all
  task automatic test_long_hold();
    write_reg(tlps_pkg::REG_PHASE_SLOTS, 4'd3);
    write_reg(tlps_pkg::REG_BLINK_SLOTS, 4'd2);
    write_reg(tlps_pkg::REG_WALK_SLOTS, 4'd4);
    ready_mode <= RX_RANDOM;
    hold_left  <= LONG_HOLD;
    gap_max    = 0;
    press_pct  = 20;
    for (int i = 0; i < 30; i++) send_slot(rand_press());
    drain_results();
  endtask

  // output transfer checker
  always @(posedge clk) begin : check_lamps
    logic [tlps_pkg::LAMP_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_lamps.size() == 0) begin
        $display("%0t ns: unexpected transfer, expected none, actual %b", $time, m_tdata);
        mismatches++;
      end else begin
        want = expected_lamps.pop_front();
        for (int i = 0; i < tlps_pkg::LAMP_W; i++)
          if (m_tdata[i] !== want[i]) begin
            $display("%0t ns: %s expected %0b actual %0b",
                     $time, lamp_name[i], want[i], m_tdata[i]);
            mismatches++;
          end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      case (ready_mode)
        RX_ALWAYS: m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(99) < 70);
        default:   m_tready <= ((cycle_cnt % 7) >= 3);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_service_per_phase();
    test_settings_sweep();
    test_long_hold();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
